FILE: rtl/core/fcc_pkg.sv
`default_nettype none

package fcc_pkg;

   localparam logic [15:0] CRC_POLY = 16'h1021;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;

   localparam logic [1:0] KIND_PAYLOAD = 2'd0;
   localparam logic [1:0] KIND_CRC_OK  = 2'd1;
   localparam logic [1:0] KIND_CRC_BAD = 2'd2;

   typedef struct packed {
      logic        has_result;
      logic [1:0]  kind;
      logic [7:0]  payload_byte;
      logic [15:0] computed_crc;
   } fcc_result_type;

   // MSB-first CRC-16 update over one byte, no reflection
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc;
      for (int i = 0; i < 8; i++) begin
         if (c[15] ^ data[3'(7 - i)]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/fcc_frame_fsm.sv
`default_nettype none

module fcc_frame_fsm
   import fcc_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           fire,
   input  wire logic [7:0]     frame_byte,
   output fcc_result_type      result
);

   localparam logic [2:0] PH_START  = 3'd0;
   localparam logic [2:0] PH_LEN_LO = 3'd1;
   localparam logic [2:0] PH_LEN_HI = 3'd2;
   localparam logic [2:0] PH_DATA   = 3'd3;
   localparam logic [2:0] PH_CRC_HI = 3'd4;
   localparam logic [2:0] PH_CRC_LO = 3'd5;
   localparam logic [2:0] PH_END    = 3'd6;

   logic [2:0]  phase_ff, phase_in;
   logic [7:0]  length_low_ff, length_low_in;
   logic [15:0] remaining_ff, remaining_in;
   logic [15:0] running_crc_ff, running_crc_in;
   logic [15:0] received_crc_ff, received_crc_in;
   logic [15:0] length_full;
   logic [15:0] remaining_dec;

   assign length_full   = {frame_byte, length_low_ff};
   assign remaining_dec = remaining_ff - 16'd1;

   always_comb begin
      phase_in        = phase_ff;
      length_low_in   = length_low_ff;
      remaining_in    = remaining_ff;
      running_crc_in  = running_crc_ff;
      received_crc_in = received_crc_ff;
      result          = '0;
      unique case (phase_ff)
         PH_LEN_LO: begin
            length_low_in = frame_byte;
            phase_in      = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            remaining_in = length_full;
            // skip the payload on a zero length
            phase_in     = (length_full == 16'd0) ? PH_CRC_HI : PH_DATA;
         end
         PH_DATA: begin
            running_crc_in      = crc_byte(running_crc_ff, frame_byte);
            remaining_in        = remaining_dec;
            if (remaining_dec == 16'd0) begin
               phase_in = PH_CRC_HI;
            end
            result.has_result   = 1'b1;
            result.kind         = KIND_PAYLOAD;
            result.payload_byte = frame_byte;
         end
         PH_CRC_HI: begin
            received_crc_in = {frame_byte, 8'h00};
            phase_in        = PH_CRC_LO;
         end
         PH_CRC_LO: begin
            received_crc_in = received_crc_ff | {8'h00, frame_byte};
            phase_in        = PH_END;
         end
         PH_END: begin
            result.has_result   = 1'b1;
            result.kind         = (received_crc_ff == running_crc_ff) ? KIND_CRC_OK
                                                                       : KIND_CRC_BAD;
            result.computed_crc = running_crc_ff;
            phase_in            = PH_START;
         end
         default: begin
            // start byte, or an unused phase code: open a new frame
            running_crc_in  = CRC_INIT;
            received_crc_in = 16'd0;
            remaining_in    = 16'd0;
            phase_in        = PH_LEN_LO;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_START;
         length_low_ff   <= 8'd0;
         remaining_ff    <= 16'd0;
         running_crc_ff  <= CRC_INIT;
         received_crc_ff <= 16'd0;
      end else if (fire) begin
         phase_ff        <= phase_in;
         length_low_ff   <= length_low_in;
         remaining_ff    <= remaining_in;
         running_crc_ff  <= running_crc_in;
         received_crc_ff <= received_crc_in;
      end
   end

`ifndef ASSERT_OFF
   a_data_has_length: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DATA) |-> (remaining_ff != 16'd0))
      else $error("payload phase entered with nothing remaining");
   a_status_only_at_end: assert property (@(posedge clock) disable iff (reset)
      (result.has_result && (result.kind != KIND_PAYLOAD)) |-> (phase_ff == PH_END))
      else $error("status result outside end byte");
   a_end_returns_start: assert property (@(posedge clock) disable iff (reset)
      (fire && (phase_ff == PH_END)) |=> (phase_ff == PH_START))
      else $error("end byte did not close the frame");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/frame_crc16_checker_top.sv
`default_nettype none
// Framed CRC-16 checker.
// Input channel (req_): one frame byte per word. A frame is a start byte, a
// 16-bit length (low byte first), that many payload bytes, a 16-bit CRC (high
// byte first) and an end byte. Start and end byte values are not checked.
// Result channel (rsp_): each payload byte is passed on with kind payload;
// the end byte yields one status word (CRC ok or mismatch) carrying the CRC
// computed over the payload. Downstream discards a frame on mismatch.
// Path: a taken byte sits in the input register and is parsed; any result word
// it yields lands in the result register, from where the receiver takes it.
// Throughput: one byte per cycle while the receiver does not stall; the CRC byte
// update is one unrolled step from the input register into the running CRC register.
// Reset clears both valid flags and returns the parser to waiting for a start
// byte with the CRC at 0xFFFF.
// While the receiver stalls, the result word holds; one more byte is taken
// into the input register, then req_stall rises until the result moves.

module frame_crc16_checker_top
   import fcc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic [7:0]  req_frame_byte,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic [1:0]  rsp_kind,
   output      logic [7:0]  rsp_payload_byte,
   output      logic [15:0] rsp_computed_crc
);

   logic           in_valid_ff;
   logic [7:0]     in_byte_ff;
   logic           out_valid_ff;
   logic [1:0]     out_kind_ff;
   logic [7:0]     out_payload_ff;
   logic [15:0]    out_crc_ff;
   logic           advance;
   logic           fire;
   logic           req_take;
   fcc_result_type result;

   assign advance   = !out_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   fcc_frame_fsm u_fsm (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .frame_byte (in_byte_ff),
      .result     (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (fire) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_frame_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (fire) begin
         out_valid_ff <= result.has_result;
      end else if (!rsp_stall) begin
         // drop the word once taken
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && result.has_result) begin
         out_kind_ff    <= result.kind;
         out_payload_ff <= result.payload_byte;
         out_crc_ff     <= result.computed_crc;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_kind         = out_kind_ff;
   assign rsp_payload_byte = out_payload_ff;
   assign rsp_computed_crc = out_crc_ff;

`ifndef ASSERT_OFF
   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_kind == KIND_PAYLOAD) || (rsp_kind == KIND_CRC_OK)
                     || (rsp_kind == KIND_CRC_BAD)))
      else $error("result word with unknown kind");
   a_payload_no_crc: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind == KIND_PAYLOAD)) |-> (rsp_computed_crc == 16'd0))
      else $error("payload word carries a CRC");
   a_status_no_byte: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind != KIND_PAYLOAD)) |-> (rsp_payload_byte == 8'd0))
      else $error("status word carries a payload byte");
   a_stall_from_downstream: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall && in_valid_ff))
      else $error("input stalled without downstream backpressure");
`endif

endmodule

`default_nettype wire
